/* rtl/imuca_pkg.sv */
// ----------------------------------------------------------------------------
// imuca_pkg
// Shared types and constants for the complementary-filter attitude unit.
// ----------------------------------------------------------------------------
package imuca_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam int ANGLE_W      = 25;
   localparam int CORDIC_W     = 40;
   localparam int ZACC_W       = 26;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 25'sd11796480;
   localparam logic signed [ZACC_W-1:0]  DEG90     = 26'sd5898240;

   localparam logic [16:0] BLEND_RESET = 17'd64225;
   localparam logic [15:0] STEP_RESET  = 16'd655;

   localparam logic [2:0] CSR_BLEND    = 3'd0;
   localparam logic [2:0] CSR_STEP     = 3'd1;
   localparam logic [2:0] CSR_OFFSET_X = 3'd2;
   localparam logic [2:0] CSR_OFFSET_Y = 3'd3;
   localparam logic [2:0] CSR_OFFSET_Z = 3'd4;

   typedef struct packed {
      logic start;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] x;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic signed [ANGLE_W-1:0] angle;
   } cordic_rsp_type;

   function automatic logic signed [ZACC_W-1:0] atan_entry(input logic [4:0] i);
      logic signed [ZACC_W-1:0] v;
      begin
         case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

/* rtl/imu_complementary_attitude_unit.sv */
// ----------------------------------------------------------------------------
// imu_complementary_attitude_unit
// Complementary-filter roll/pitch/yaw estimator over raw six-axis samples.
// ----------------------------------------------------------------------------
// One sample at a time: a new input transfer is not taken until the result
// of the one before has been taken. The time is set by three passes of the
// 20-step CORDIC (its steps are skipped when both operands are zero), two
// 24-step square roots and fifteen multiply steps on one shared multiplier,
// all sequenced one after another. req_stall is high from a transfer until
// the result has been taken. rsp_* is held until taken.
module imu_complementary_attitude_unit
   import imuca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_rate_x,
   input  logic signed [15:0] req_rate_y,
   input  logic signed [15:0] req_rate_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_roll_out,
   output logic signed [ANGLE_W-1:0] rsp_pitch_out,
   output logic signed [ANGLE_W-1:0] rsp_yaw_out,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_SQ1    = 5'd1;
   localparam logic [4:0] S_SQW1   = 5'd2;
   localparam logic [4:0] S_CR1    = 5'd3;
   localparam logic [4:0] S_SQ2    = 5'd4;
   localparam logic [4:0] S_SQW2   = 5'd5;
   localparam logic [4:0] S_CR2    = 5'd6;
   localparam logic [4:0] S_CR3    = 5'd7;
   localparam logic [4:0] S_M_GX   = 5'd8;
   localparam logic [4:0] S_M_GY   = 5'd9;
   localparam logic [4:0] S_M_GZ   = 5'd10;
   localparam logic [4:0] S_M_GXT  = 5'd11;
   localparam logic [4:0] S_M_GYT  = 5'd12;
   localparam logic [4:0] S_M_YR   = 5'd13;
   localparam logic [4:0] S_M_B1   = 5'd14;
   localparam logic [4:0] S_M_B2   = 5'd15;
   localparam logic [4:0] S_M_BT   = 5'd16;
   localparam logic [4:0] S_M_R1   = 5'd17;
   localparam logic [4:0] S_M_R2   = 5'd18;
   localparam logic [4:0] S_M_P1   = 5'd19;
   localparam logic [4:0] S_M_P2   = 5'd20;
   localparam logic [4:0] S_M_Y1   = 5'd21;
   localparam logic [4:0] S_M_Y2   = 5'd22;
   localparam logic [4:0] S_OUT    = 5'd23;

   // ceil(2^40/131); diff * RECIP131 >>> 24 gives diff*65536/131
   localparam logic signed [35:0] RECIP131 = 36'sd8393218533;

   logic [4:0]  state_ff, state_in;
   logic [16:0] blend_ff;
   logic [15:0] step_ff;
   logic signed [15:0] offx_ff, offy_ff, offz_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff, rx_ff, ry_ff, rz_ff;
   logic signed [ANGLE_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic signed [31:0] bias_ff, drift_ff;
   logic signed [ANGLE_W-1:0] acc_roll_ff, acc_pitch_ff, yaw_deg_ff;
   logic signed [31:0] gx_ff, gy_ff, gz_ff;
   logic signed [47:0] accum_ff;
   logic signed [47:0] gxt_ff, gyt_ff, yrad_ff;
   logic               rsp_valid_ff;

   // shared multiplier
   logic signed [35:0] mul_a, mul_b;
   logic signed [71:0] mul_p;
   logic signed [71:0] prod_ff;
   assign mul_p = mul_a * mul_b;

   logic [16:0] alpha;
   assign alpha = (blend_ff > 17'd65536) ? 17'd65536 : blend_ff;

   cordic_req_type creq;
   cordic_rsp_type crsp;
   logic           sq_start, sq_done;
   logic [47:0]    sq_rad;
   logic [23:0]    sq_root;
   logic signed [16:0] diff;

   imuca_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand(sq_rad), .done(sq_done), .root(sq_root)
   );

   imuca_cordic u_cordic (
      .clock(clock), .reset(reset), .req(creq), .rsp(crsp)
   );

   logic signed [32:0] sa, sb;
   always_comb begin
      sa = '0;
      sb = '0;
      if (state_ff == S_SQ1) begin
         sa = 33'(ax_ff) * 33'(ax_ff);
         sb = 33'(az_ff) * 33'(az_ff);
      end else begin
         sa = 33'(ay_ff) * 33'(ay_ff);
         sb = 33'(az_ff) * 33'(az_ff);
      end
      sq_rad = {15'd0, 33'(sa + sb)} << 16;
      sq_start = (state_ff == S_SQ1) || (state_ff == S_SQ2);
   end

   always_comb begin
      creq.start = 1'b0;
      creq.x     = '0;
      creq.y     = '0;
      if (state_ff == S_SQW1 && sq_done) begin
         creq.start = 1'b1;
         creq.y     = CORDIC_W'(ay_ff) <<< 8;
         creq.x     = CORDIC_W'({1'b0, sq_root});
      end else if (state_ff == S_SQW2 && sq_done) begin
         creq.start = 1'b1;
         creq.y     = -(CORDIC_W'(ax_ff) <<< 8);
         creq.x     = CORDIC_W'({1'b0, sq_root});
      end else if (state_ff == S_CR2 && crsp.done) begin
         creq.start = 1'b1;
         creq.y     = CORDIC_W'(ay_ff) <<< 8;
         creq.x     = CORDIC_W'(az_ff) <<< 8;
      end
   end

   always_comb begin
      diff = 17'(rx_ff) - 17'(offx_ff);
      case (state_ff)
         S_M_GY:  diff = 17'(ry_ff) - 17'(offy_ff);
         S_M_GZ:  diff = 17'(rz_ff) - 17'(offz_ff);
         default: diff = 17'(rx_ff) - 17'(offx_ff);
      endcase
   end

   // truncation toward zero of diff*65536/131 via reciprocal (exact for |diff|<2^17)
   function automatic logic signed [31:0] div131(input logic signed [71:0] p);
      logic signed [71:0] q;
      begin
         q = p >>> 24;
         if (p < 0) q = q + 72'sd1;
         return 32'(q);
      end
   endfunction

   function automatic logic signed [ANGLE_W-1:0] sat_ang(input logic signed [47:0] v);
      begin
         if (v > 48'(ANGLE_MAX))       return ANGLE_MAX;
         else if (v < -48'(ANGLE_MAX)) return -ANGLE_MAX;
         else                          return ANGLE_W'(v);
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      begin
         if (v > 48'sh7FFF_FFFF)         return 32'sh7FFF_FFFF;
         else if (v < -48'sh8000_0000)   return 32'sh8000_0000;
         else                            return 32'(v);
      end
   endfunction

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_M_GX, S_M_GY, S_M_GZ: begin
            mul_a = 36'(diff);
            mul_b = RECIP131;
         end
         S_M_GXT: begin mul_a = 36'(gx_ff); mul_b = 36'({1'b0, step_ff}); end
         S_M_GYT: begin mul_a = 36'(gy_ff); mul_b = 36'({1'b0, step_ff}); end
         S_M_YR:  begin mul_a = 36'(yaw_deg_ff); mul_b = 36'sd74961321; end
         S_M_B1:  begin mul_a = 36'(bias_ff); mul_b = 36'sd58982; end
         S_M_B2:  begin mul_a = 36'(gz_ff); mul_b = 36'sd655; end
         S_M_BT:  begin mul_a = 36'(bias_ff); mul_b = 36'({1'b0, step_ff}); end
         S_M_R1:  begin mul_a = 36'(alpha); mul_b = 36'(accum_ff); end
         S_M_R2:  begin mul_a = 36'(18'sd65536 - 18'(alpha)); mul_b = 36'(acc_roll_ff); end
         S_M_P1:  begin mul_a = 36'(alpha); mul_b = 36'(accum_ff); end
         S_M_P2:  begin mul_a = 36'(18'sd65536 - 18'(alpha)); mul_b = 36'(acc_pitch_ff); end
         S_M_Y1:  begin mul_a = 36'(alpha); mul_b = 36'(accum_ff); end
         S_M_Y2:  begin mul_a = 36'(18'sd65536 - 18'(alpha)); mul_b = 36'(yrad_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         blend_ff     <= BLEND_RESET;
         step_ff      <= STEP_RESET;
         offx_ff      <= '0;
         offy_ff      <= '0;
         offz_ff      <= '0;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         yaw_ff       <= '0;
         bias_ff      <= '0;
         drift_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_BLEND:    blend_ff <= csr_data;
               CSR_STEP:     step_ff  <= csr_data[15:0];
               CSR_OFFSET_X: offx_ff  <= csr_data[15:0];
               CSR_OFFSET_Y: offy_ff  <= csr_data[15:0];
               CSR_OFFSET_Z: offz_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) begin
               ax_ff <= req_accel_x; ay_ff <= req_accel_y; az_ff <= req_accel_z;
               rx_ff <= req_rate_x;  ry_ff <= req_rate_y;  rz_ff <= req_rate_z;
            end
            S_CR1:   if (crsp.done) acc_roll_ff <= crsp.angle;
            S_CR2:   if (crsp.done) acc_pitch_ff <= crsp.angle;
            S_CR3:   if (crsp.done) yaw_deg_ff <= crsp.angle;
            S_M_GX:  gx_ff <= div131(mul_p);
            S_M_GY:  gy_ff <= div131(mul_p);
            S_M_GZ:  gz_ff <= div131(mul_p);
            S_M_GXT: gxt_ff <= 48'(mul_p >>> 16);
            S_M_GYT: gyt_ff <= 48'(mul_p >>> 16);
            S_M_YR:  yrad_ff <= 48'(mul_p >>> 32);
            S_M_B1:  prod_ff <= mul_p;
            S_M_B2:  bias_ff <= sat32(48'((prod_ff + mul_p) >>> 16));
            S_M_BT: begin
               drift_ff <= sat32(48'(drift_ff) - 48'(mul_p >>> 16));
               accum_ff <= 48'(roll_ff) + gxt_ff;
            end
            S_M_R1:  prod_ff <= mul_p;
            S_M_R2: begin
               roll_ff  <= sat_ang(48'((prod_ff + mul_p) >>> 16));
               accum_ff <= 48'(pitch_ff) + gyt_ff;
            end
            S_M_P1:  prod_ff <= mul_p;
            S_M_P2: begin
               pitch_ff <= sat_ang(48'((prod_ff + mul_p) >>> 16));
               accum_ff <= 48'(yaw_ff) + 48'(drift_ff);
            end
            S_M_Y1:  prod_ff <= mul_p;
            S_M_Y2: begin
               yaw_ff       <= sat_ang(48'((prod_ff + mul_p) >>> 16));
               rsp_valid_ff <= 1'b1;
            end
            S_OUT: if (!rsp_stall) rsp_valid_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_SQ1;
         S_SQ1:   state_in = S_SQW1;
         S_SQW1:  if (sq_done) state_in = S_CR1;
         S_CR1:   if (crsp.done) state_in = S_SQ2;
         S_SQ2:   state_in = S_SQW2;
         S_SQW2:  if (sq_done) state_in = S_CR2;
         S_CR2:   if (crsp.done) state_in = S_CR3;
         S_CR3:   if (crsp.done) state_in = S_M_GX;
         S_M_GX:  state_in = S_M_GY;
         S_M_GY:  state_in = S_M_GZ;
         S_M_GZ:  state_in = S_M_GXT;
         S_M_GXT: state_in = S_M_GYT;
         S_M_GYT: state_in = S_M_YR;
         S_M_YR:  state_in = S_M_B1;
         S_M_B1:  state_in = S_M_B2;
         S_M_B2:  state_in = S_M_BT;
         S_M_BT:  state_in = S_M_R1;
         S_M_R1:  state_in = S_M_R2;
         S_M_R2:  state_in = S_M_P1;
         S_M_P1:  state_in = S_M_P2;
         S_M_P2:  state_in = S_M_Y1;
         S_M_Y1:  state_in = S_M_Y2;
         S_M_Y2:  state_in = S_OUT;
         S_OUT:   if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_roll_out  = roll_ff;
   assign rsp_pitch_out = pitch_ff;
   assign rsp_yaw_out   = yaw_ff;

endmodule

/* rtl/imuca_cordic.sv */
// ----------------------------------------------------------------------------
// imuca_cordic
// Iterative vectoring CORDIC: atan2(y, x) in degrees Q16, one step per cycle.
// ----------------------------------------------------------------------------
module imuca_cordic
   import imuca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [4:0]                 step_ff, step_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZACC_W-1:0]   z_ff, z_in;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [ZACC_W-1:0]   zc;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (req.start) begin
         step_in = '0;
         if (req.x == '0 && req.y == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            z_in    = '0;
         end else begin
            busy_in = 1'b1;
            x_in    = req.x;
            y_in    = req.y;
            z_in    = '0;
            if (req.x < 0) begin
               if (req.y >= 0) begin
                  x_in = req.y;
                  y_in = -req.x;
                  z_in = DEG90;
               end else begin
                  x_in = -req.y;
                  y_in = req.x;
                  z_in = -DEG90;
               end
            end
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_entry(step_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_entry(step_ff);
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   always_comb begin
      if (z_ff > ZACC_W'(ANGLE_MAX))       zc = ZACC_W'(ANGLE_MAX);
      else if (z_ff < -ZACC_W'(ANGLE_MAX)) zc = -ZACC_W'(ANGLE_MAX);
      else                                 zc = z_ff;
   end

   assign rsp.done  = done_ff;
   assign rsp.angle = ANGLE_W'(zc);

endmodule

/* rtl/imuca_isqrt.sv */
// ----------------------------------------------------------------------------
// imuca_isqrt
// Bit-serial floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module imuca_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] radicand,
   output logic        done,
   output logic [23:0] root
);

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [47:0] n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic [47:0] trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = radicand;
         r_in    = '0;
         bit_in  = 48'h4000_0000_0000;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in = n_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[23:0];

endmodule

/* test/imu_complementary_attitude_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_complementary_attitude_unit_tb
// Streams raw six-axis samples through the attitude unit under several filter
// settings. An in-bench fixed-point filter tracks roll, pitch, yaw and the
// yaw bias and drift, and each transfer on the output side is checked against
// the oldest predicted attitude. Random gaps and stalls are used on both sides.
// ----------------------------------------------------------------------------
module imu_complementary_attitude_unit_tb;
   import imuca_pkg::*;

   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE = 300;
   localparam longint ANG_LIM = 11796480;
   localparam longint QUARTER = 5898240;
   localparam longint ONE = 65536;

   typedef struct {
      logic signed [15:0] ax, ay, az, gx, gy, gz;
   } sample_type;

   typedef struct {
      logic signed [ANGLE_W-1:0] roll, pitch, yaw;
   } attitude_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [15:0] req_rate_x = '0, req_rate_y = '0, req_rate_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ANGLE_W-1:0] rsp_roll_out, rsp_pitch_out, rsp_yaw_out;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [16:0] csr_data = '0;

   sample_type samples_pending[$];
   attitude_type attitude_expected[$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   longint alpha_reg, dt_reg, off_x, off_y, off_z;
   longint roll_st, pitch_st, yaw_st, bias_st, drift_st;

   longint atan_steps[CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7};

   imu_complementary_attitude_unit uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint limit(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint root_floor(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint heading_deg(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + atan_steps[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_steps[i];
         end
      end
      return limit(z, -ANG_LIM, ANG_LIM);
   endfunction

   function automatic longint tilt_deg(longint num, longint a, longint b);
      longint unsigned sq;
      sq = longint'(a * a + b * b) << 16;
      return heading_deg(num * 256, root_floor(sq));
   endfunction

   function automatic longint blend(longint a, longint g, longint acc);
      return (a * g + (ONE - a) * acc) >>> 16;
   endfunction

   function automatic void filter_step(sample_type s);
      longint ax, ay, az, rx, ry, rz, a, acc_r, acc_p, yaw_rad, r, p, y;
      attitude_type e;
      ax = longint'(s.ax); ay = longint'(s.ay); az = longint'(s.az);
      rx = ((longint'(s.gx) - off_x) * ONE) / 131;
      ry = ((longint'(s.gy) - off_y) * ONE) / 131;
      rz = ((longint'(s.gz) - off_z) * ONE) / 131;
      a = alpha_reg > ONE ? ONE : alpha_reg;
      acc_r = tilt_deg(ay, ax, az);
      acc_p = tilt_deg(-ax, ay, az);
      yaw_rad = (heading_deg(ay * 256, az * 256) * 74961321) >>> 32;
      r = roll_st + ((rx * dt_reg) >>> 16);
      p = pitch_st + ((ry * dt_reg) >>> 16);
      roll_st = limit(blend(a, r, acc_r), -ANG_LIM, ANG_LIM);
      pitch_st = limit(blend(a, p, acc_p), -ANG_LIM, ANG_LIM);
      bias_st = limit((58982 * bias_st + 655 * rz) >>> 16, -(64'sd1 << 31),
                      (64'sd1 << 31) - 1);
      drift_st = limit(drift_st - ((bias_st * dt_reg) >>> 16), -(64'sd1 << 31),
                       (64'sd1 << 31) - 1);
      y = yaw_st + drift_st;
      yaw_st = limit(blend(a, y, yaw_rad), -ANG_LIM, ANG_LIM);
      e.roll = roll_st[ANGLE_W-1:0];
      e.pitch = pitch_st[ANGLE_W-1:0];
      e.yaw = yaw_st[ANGLE_W-1:0];
      attitude_expected.push_back(e);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // sender
   int send_gap = 0;
   always @(posedge clock) begin
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            filter_step(samples_pending.pop_front());
            send_gap = pick_gap();
         end
         if (!req_valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (samples_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_accel_x <= samples_pending[0].ax;
               req_accel_y <= samples_pending[0].ay;
               req_accel_z <= samples_pending[0].az;
               req_rate_x <= samples_pending[0].gx;
               req_rate_y <= samples_pending[0].gy;
               req_rate_z <= samples_pending[0].gz;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   int stall_left = 0;
   always @(posedge clock) begin
      attitude_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (attitude_expected.size() == 0) begin
               $error("result transfer with no expected attitude");
               fail_count++;
            end else begin
               e = attitude_expected.pop_front();
               if (rsp_roll_out !== e.roll) begin
                  $error("roll_out expected %0d got %0d", e.roll, rsp_roll_out);
                  fail_count++;
               end
               if (rsp_pitch_out !== e.pitch) begin
                  $error("pitch_out expected %0d got %0d", e.pitch, rsp_pitch_out);
                  fail_count++;
               end
               if (rsp_yaw_out !== e.yaw) begin
                  $error("yaw_out expected %0d got %0d", e.yaw, rsp_yaw_out);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_all(longint blend_w, longint dt, longint ox, longint oy,
                            longint oz);
      logic [2:0] idx[6];
      longint val[6];
      idx = '{CSR_BLEND, CSR_STEP, CSR_OFFSET_X, CSR_OFFSET_Y, CSR_OFFSET_Z, CSR_SPARE};
      val = '{blend_w, dt, ox, oy, oz, $urandom};
      for (int i = 0; i < 6; i++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i][16:0];
      end
      @(posedge clock);
      csr_write <= 1'b0;
      alpha_reg = blend_w & 64'h1FFFF;
      dt_reg = dt & 64'hFFFF;
      off_x = longint'(signed'(ox[15:0]));
      off_y = longint'(signed'(oy[15:0]));
      off_z = longint'(signed'(oz[15:0]));
   endtask

   task automatic add_sample(int ax, int ay, int az, int gx, int gy, int gz);
      sample_type s;
      s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
      s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
      samples_pending.push_back(s);
   endtask

   function automatic int near_val(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 6)
            add_sample(near_val(4000), near_val(4000), 16384 + near_val(3000),
                       near_val(2000), near_val(2000), near_val(2000));
         else
            add_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic drain();
      wait (samples_pending.size() == 0 && attitude_expected.size() == 0 && !req_valid);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      alpha_reg = longint'(BLEND_RESET); dt_reg = longint'(STEP_RESET);
      off_x = 0; off_y = 0; off_z = 0;
      roll_st = 0; pitch_st = 0; yaw_st = 0; bias_st = 0; drift_st = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero vectors, extremes, each quadrant of the angle
      add_sample(0, 0, 0, 0, 0, 0);
      add_sample(32767, 32767, 32767, 32767, 32767, 32767);
      add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
      add_sample(0, 16384, -16384, 0, 0, 0);
      add_sample(0, -16384, -16384, 0, 0, 0);
      add_sample(16384, 0, 0, 100, -100, 50);
      add_sample(-16384, 0, 16384, -100, 100, -50);
      add_sample(0, 0, 16384, 0, 0, 0);
      add_sample(0, 5, -1, 0, 0, 0);
      add_sample(0, -5, -1, 0, 0, 0);
      add_random(150);
      drain();

      // full gyro weight and longest step drive the angles into saturation
      quiet = 1'b1;
      write_all(65536, 65535, 0, 0, 0);
      for (int i = 0; i < 6; i++) add_sample(0, 0, 16384, 32767, 32767, 32767);
      for (int i = 0; i < 6; i++) add_sample(0, 0, 16384, -32768, -32768, -32768);
      add_random(150);
      drain();
      quiet = 1'b0;

      write_all(131071, 1, -32768, 32767, -32768);
      add_sample(0, 0, 0, 32767, -32768, 32767);
      add_random(120);
      drain();

      write_all(0, 0, 32767, -32768, 32767);
      add_random(120);
      drain();

      for (int k = 0; k < 4; k++) begin
         write_all($urandom_range(131071), $urandom_range(65535), $urandom, $urandom,
                   $urandom);
         add_random(120);
         drain();
      end

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && samples_pending.size() == 0 && attitude_expected.size() > 0
          && !rsp_valid && !req_valid && idle_cycles == IDLE_LIMIT - 1) begin
         $error("expected attitude left over");
         fail_count++;
      end
   end

endmodule

/* files.f */
rtl/imuca_pkg.sv
rtl/imuca_cordic.sv
rtl/imuca_isqrt.sv
rtl/imu_complementary_attitude_unit.sv
test/imu_complementary_attitude_unit_tb.sv
